// ===== rtl/cet_pkg.sv =====
// shared types, constants and character helpers for the expression tokenizer
// no dependencies
package cet_pkg;

	localparam int unsigned TEXT_LEN_MAX_DEF = 65535;
	localparam int unsigned IN_Q_DEPTH = 2;
	localparam int unsigned OUT_Q_DEPTH = 4;

	localparam logic [15:0] POS_CAP = 16'hFFFF;
	localparam logic [10:0] DIGIT_CAP = 11'd1024;
	localparam logic [15:0] MAX_TOKENS_RST = 16'd65535;
	localparam logic [9:0] MAX_DIGITS_RST = 10'd1023;

	// register indexes
	localparam logic CFG_MAX_TOKENS = 1'b0;
	localparam logic CFG_MAX_DIGITS = 1'b1;

	// literal flag bits
	localparam int unsigned LF_ZERO = 0;
	localparam int unsigned LF_MULTI = 1;
	localparam int unsigned LF_DIGIT = 2;
	localparam int unsigned LF_POINT = 3;
	localparam int unsigned LF_ESC = 4;

	// token kinds
	localparam logic [4:0] TK_END = 5'd0;
	localparam logic [4:0] TK_NUM = 5'd1;
	localparam logic [4:0] TK_IDENT = 5'd2;
	localparam logic [4:0] TK_STR = 5'd3;
	localparam logic [4:0] TK_PLUS = 5'd4;
	localparam logic [4:0] TK_MINUS = 5'd5;
	localparam logic [4:0] TK_STAR = 5'd6;
	localparam logic [4:0] TK_SLASH = 5'd7;
	localparam logic [4:0] TK_CARET = 5'd8;
	localparam logic [4:0] TK_LPAR = 5'd9;
	localparam logic [4:0] TK_RPAR = 5'd10;
	localparam logic [4:0] TK_LBRK = 5'd11;
	localparam logic [4:0] TK_RBRK = 5'd12;
	localparam logic [4:0] TK_LBRC = 5'd13;
	localparam logic [4:0] TK_RBRC = 5'd14;
	localparam logic [4:0] TK_COMMA = 5'd15;
	localparam logic [4:0] TK_PCT = 5'd16;
	localparam logic [4:0] TK_AT = 5'd17;
	localparam logic [4:0] TK_ASSIGN = 5'd18;
	localparam logic [4:0] TK_LE = 5'd19;
	localparam logic [4:0] TK_LT = 5'd20;
	localparam logic [4:0] TK_GE = 5'd21;
	localparam logic [4:0] TK_GT = 5'd22;
	localparam logic [4:0] TK_EQ = 5'd23;
	localparam logic [4:0] TK_NE = 5'd24;
	localparam logic [4:0] TK_NOT = 5'd25;

	// error codes
	localparam logic [3:0] ERR_NONE = 4'd0;
	localparam logic [3:0] ERR_COLON = 4'd1;
	localparam logic [3:0] ERR_LONE_EQ = 4'd2;
	localparam logic [3:0] ERR_CHAR = 4'd3;
	localparam logic [3:0] ERR_POINT2 = 4'd4;
	localparam logic [3:0] ERR_RADIX = 4'd5;
	localparam logic [3:0] ERR_PREFIX = 4'd6;
	localparam logic [3:0] ERR_EXP = 4'd7;
	localparam logic [3:0] ERR_DOT = 4'd8;
	localparam logic [3:0] ERR_STRING = 4'd9;
	localparam logic [3:0] ERR_TOKENS = 4'd10;
	localparam logic [3:0] ERR_DIGITS = 4'd11;

	// characters
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_USCORE = 8'h5F;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_LE_E = 8'h65;
	localparam logic [7:0] CH_UE_E = 8'h45;
	localparam logic [7:0] CH_LB = 8'h62;
	localparam logic [7:0] CH_UB = 8'h42;
	localparam logic [7:0] CH_LO = 8'h6F;
	localparam logic [7:0] CH_UO = 8'h4F;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_LPAR = 8'h28;
	localparam logic [7:0] CH_RPAR = 8'h29;
	localparam logic [7:0] CH_LBRK = 8'h5B;
	localparam logic [7:0] CH_RBRK = 8'h5D;
	localparam logic [7:0] CH_LBRC = 8'h7B;
	localparam logic [7:0] CH_RBRC = 8'h7D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_AT = 8'h40;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_BANG = 8'h21;

	typedef enum logic [3:0] {
		M_IDLE, M_INT, M_FRAC, M_RADIX, M_PREFIX,
		M_EXPCHK, M_EXPDIG, M_TAIL, M_IDENT, M_STR
	} lex_mode_t;

	typedef enum logic {PH_TAKE, PH_RUN} phase_t;

	typedef struct packed {
		logic [15:0] off;
		logic [15:0] line;
		logic [15:0] col;
	} pos_t;

	typedef struct packed {
		logic [7:0] chr;
		logic has;
		logic eot;
	} in_item_t;

	typedef struct packed {
		logic [4:0] kind;
		logic [3:0] err;
		pos_t start;
		pos_t fin;
		logic done;
	} res_t;

	typedef struct packed {
		res_t res;
		logic last;
	} out_item_t;

	localparam pos_t POS_RST = '{off: 16'd0, line: 16'd1, col: 16'd1};

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || is_letter(c);
	endfunction

	function automatic logic is_id_start(input logic [7:0] c);
		return is_letter(c) || c == CH_USCORE;
	endfunction

	function automatic logic is_id_cont(input logic [7:0] c);
		return is_id_start(c) || is_digit(c);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_prefix(input logic [7:0] c);
		return c == CH_LB || c == CH_UB || c == CH_LO || c == CH_UO ||
			c == CH_LX || c == CH_UX;
	endfunction

	function automatic logic is_pair_op(input logic [7:0] c);
		return c == CH_COLON || c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG;
	endfunction

	function automatic logic [4:0] single_op(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			CH_PLUS:  k = TK_PLUS;
			CH_MINUS: k = TK_MINUS;
			CH_STAR:  k = TK_STAR;
			CH_SLASH: k = TK_SLASH;
			CH_CARET: k = TK_CARET;
			CH_LPAR:  k = TK_LPAR;
			CH_RPAR:  k = TK_RPAR;
			CH_LBRK:  k = TK_LBRK;
			CH_RBRK:  k = TK_RBRK;
			CH_LBRC:  k = TK_LBRC;
			CH_RBRC:  k = TK_RBRC;
			CH_COMMA: k = TK_COMMA;
			CH_PCT:   k = TK_PCT;
			CH_AT:    k = TK_AT;
			default:  k = TK_END;
		endcase
		return k;
	endfunction

	// move a position past one byte, counters saturate
	function automatic pos_t adv_pos(input pos_t p, input logic [7:0] c);
		pos_t r;
		r = p;
		if (p.off != POS_CAP) r.off = p.off + 16'd1;
		if (c == CH_LF) begin
			if (p.line != POS_CAP) r.line = p.line + 16'd1;
			r.col = 16'd1;
		end else if (p.col != POS_CAP) begin
			r.col = p.col + 16'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/cet_fifo.sv =====
// small register queue with first-word-fall-through read
// no dependencies
module cet_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/cet_front.sv =====
// input side: takes source items, drops empty ones, queues the rest
// depends on cet_pkg and cet_fifo
module cet_front import cet_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       has_char,
	input  logic       end_of_text,
	output logic       q_valid,
	input  logic       q_ready,
	output in_item_t   q_item
);
	in_item_t wr_item;
	logic wr_ready;

	assign wr_item = '{chr: char_byte, has: has_char, eot: end_of_text};

	cet_fifo #(
		.WIDTH($bits(in_item_t)),
		.DEPTH(IN_Q_DEPTH)
	) u_inq (
		.clk(clk),
		.arst_n(arst_n),
		// an item with no byte and no end mark changes nothing
		.wr_valid(in_valid && (has_char || end_of_text)),
		.wr_ready(wr_ready),
		.wr_data(wr_item),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data(q_item)
	);

	assign in_ready = wr_ready;

endmodule

// ===== rtl/cet_back.sv =====
// lexer engine: holds lookahead and position state, one lexer step per cycle while res_ready is high
// depends on cet_pkg
module cet_back import cet_pkg::*; #(
	parameter int unsigned TEXT_LEN_MAX = TEXT_LEN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] max_tokens,
	input  logic [9:0]  max_digits,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        res_valid,
	input  logic        res_ready,
	output out_item_t   res
);
	localparam int unsigned BT_W = $clog2(TEXT_LEN_MAX + 1);

	phase_t phase_q, phase_d;
	lex_mode_t mode_q;
	pos_t start_q, cur_q;
	logic [7:0] held_q [3];
	logic [1:0] hcnt_q;
	logic [10:0] dcnt_q;
	logic [15:0] tcnt_q;
	logic [4:0] flags_q;
	logic drop_q, ended_q, fin_q;
	logic [BT_W-1:0] btaken_q;
	logic pend_valid_q;
	res_t pend_q;

	logic [7:0] c0, c1, c2;
	logic have1, have2, have3;
	logic [10:0] dcnt_inc;

	// one step of the lexer
	logic it_ret, it_mark;
	logic [1:0] it_adv;
	lex_mode_t n_mode;
	logic [4:0] n_flags;
	logic [10:0] n_dcnt;
	logic want_emit, emit_num, want_fail;
	logic [4:0] emit_kind;
	logic [3:0] fail_code;

	logic it_res, it_fin;
	res_t it_r;
	logic [15:0] n_tcnt;
	lex_mode_t mode_fin;
	pos_t pos1, pos2;

	logic take, step_go, wrap, apply;
	logic take_push;

	assign c0 = (hcnt_q != 2'd0) ? held_q[0] : 8'h00;
	assign c1 = (hcnt_q > 2'd1) ? held_q[1] : 8'h00;
	assign c2 = (hcnt_q == 2'd3) ? held_q[2] : 8'h00;
	assign have1 = (hcnt_q != 2'd0) || ended_q;
	assign have2 = (hcnt_q > 2'd1) || ended_q;
	assign have3 = (hcnt_q == 2'd3) || ended_q;
	assign dcnt_inc = (dcnt_q < DIGIT_CAP) ? dcnt_q + 11'd1 : dcnt_q;

	always_comb begin
		it_ret = 1'b0;
		it_mark = 1'b0;
		it_adv = 2'd0;
		n_mode = mode_q;
		n_flags = flags_q;
		n_dcnt = dcnt_q;
		want_emit = 1'b0;
		emit_kind = TK_END;
		emit_num = 1'b0;
		want_fail = 1'b0;
		fail_code = ERR_NONE;
		if (mode_q == M_IDLE) begin
			if (hcnt_q == 2'd0) begin
				if (!ended_q) it_ret = 1'b1;
				else begin
					it_mark = 1'b1;
					want_emit = 1'b1;
					emit_kind = TK_END;
				end
			end else if (is_space(c0)) begin
				it_adv = 2'd1;
			end else if (is_digit(c0)) begin
				it_mark = 1'b1;
				n_dcnt = '0;
				n_flags = '0;
				n_flags[LF_ZERO] = c0 == CH_ZERO;
				n_mode = M_INT;
			end else if (c0 == CH_DOT) begin
				if (!have2) it_ret = 1'b1;
				else begin
					it_mark = 1'b1;
					it_adv = 2'd1;
					if (is_digit(c1)) begin
						n_dcnt = '0;
						n_flags = '0;
						n_mode = M_FRAC;
					end else begin
						want_fail = 1'b1;
						fail_code = ERR_CHAR;
					end
				end
			end else if (is_id_start(c0)) begin
				it_mark = 1'b1;
				n_mode = M_IDENT;
			end else if (c0 == CH_QUOTE) begin
				it_mark = 1'b1;
				it_adv = 2'd1;
				n_flags = '0;
				n_mode = M_STR;
			end else if (single_op(c0) != TK_END) begin
				it_mark = 1'b1;
				it_adv = 2'd1;
				want_emit = 1'b1;
				emit_kind = single_op(c0);
			end else if (is_pair_op(c0)) begin
				if (!have2) it_ret = 1'b1;
				else begin
					it_mark = 1'b1;
					it_adv = (c1 == CH_EQ) ? 2'd2 : 2'd1;
					case (c0)
						CH_COLON: begin
							if (c1 == CH_EQ) begin
								want_emit = 1'b1;
								emit_kind = TK_ASSIGN;
							end else begin
								want_fail = 1'b1;
								fail_code = ERR_COLON;
							end
						end
						CH_LT: begin
							want_emit = 1'b1;
							emit_kind = (c1 == CH_EQ) ? TK_LE : TK_LT;
						end
						CH_GT: begin
							want_emit = 1'b1;
							emit_kind = (c1 == CH_EQ) ? TK_GE : TK_GT;
						end
						CH_EQ: begin
							if (c1 == CH_EQ) begin
								want_emit = 1'b1;
								emit_kind = TK_EQ;
							end else begin
								want_fail = 1'b1;
								fail_code = ERR_LONE_EQ;
							end
						end
						default: begin
							want_emit = 1'b1;
							emit_kind = (c1 == CH_EQ) ? TK_NE : TK_NOT;
						end
					endcase
				end
			end else begin
				it_mark = 1'b1;
				it_adv = 2'd1;
				want_fail = 1'b1;
				fail_code = ERR_CHAR;
			end
		end else if (mode_q == M_STR) begin
			if (hcnt_q == 2'd0) begin
				if (ended_q) begin
					want_fail = 1'b1;
					fail_code = ERR_STRING;
				end else begin
					it_ret = 1'b1;
				end
			end else begin
				it_adv = 2'd1;
				if (flags_q[LF_ESC]) n_flags[LF_ESC] = 1'b0;
				else if (c0 == CH_BSLASH) n_flags[LF_ESC] = 1'b1;
				else if (c0 == CH_QUOTE) begin
					want_emit = 1'b1;
					emit_kind = TK_STR;
				end
			end
		end else if (!have1) begin
			it_ret = 1'b1;
		end else begin
			unique case (mode_q)
				M_INT: begin
					if (is_digit(c0)) begin
						if (dcnt_q != '0) n_flags[LF_MULTI] = 1'b1;
						n_dcnt = dcnt_inc;
						it_adv = 2'd1;
					end else if (c0 == CH_HASH) begin
						it_adv = 2'd1;
						n_flags[LF_DIGIT] = 1'b0;
						n_flags[LF_POINT] = 1'b0;
						n_mode = M_RADIX;
					end else if (flags_q[LF_ZERO] && !flags_q[LF_MULTI] && is_prefix(c0)) begin
						it_adv = 2'd1;
						n_flags[LF_DIGIT] = 1'b0;
						n_mode = M_PREFIX;
					end else if (c0 == CH_DOT) begin
						it_adv = 2'd1;
						n_mode = M_FRAC;
					end else begin
						n_mode = M_EXPCHK;
					end
				end
				M_FRAC, M_EXPDIG: begin
					if (is_digit(c0)) begin
						n_dcnt = dcnt_inc;
						it_adv = 2'd1;
					end else begin
						n_mode = (mode_q == M_FRAC) ? M_EXPCHK : M_TAIL;
					end
				end
				M_RADIX: begin
					if (is_alnum(c0)) begin
						n_flags[LF_DIGIT] = 1'b1;
						n_dcnt = dcnt_inc;
						it_adv = 2'd1;
					end else if (c0 == CH_DOT) begin
						if (flags_q[LF_POINT]) begin
							want_fail = 1'b1;
							fail_code = ERR_POINT2;
						end else begin
							n_flags[LF_POINT] = 1'b1;
							it_adv = 2'd1;
						end
					end else if (flags_q[LF_DIGIT]) begin
						want_emit = 1'b1;
						emit_kind = TK_NUM;
						emit_num = 1'b1;
					end else begin
						want_fail = 1'b1;
						fail_code = ERR_RADIX;
					end
				end
				M_PREFIX: begin
					if (is_alnum(c0)) begin
						n_flags[LF_DIGIT] = 1'b1;
						n_dcnt = dcnt_inc;
						it_adv = 2'd1;
					end else if (flags_q[LF_DIGIT]) begin
						want_emit = 1'b1;
						emit_kind = TK_NUM;
						emit_num = 1'b1;
					end else begin
						want_fail = 1'b1;
						fail_code = ERR_PREFIX;
					end
				end
				M_EXPCHK: begin
					if (c0 != CH_LE_E && c0 != CH_UE_E) n_mode = M_TAIL;
					else if (!have2) it_ret = 1'b1;
					else if (is_digit(c1)) begin
						it_adv = 2'd1;
						n_mode = M_EXPDIG;
					end else if (c1 == CH_PLUS || c1 == CH_MINUS) begin
						if (!have3) it_ret = 1'b1;
						else begin
							it_adv = 2'd2;
							if (is_digit(c2)) n_mode = M_EXPDIG;
							else begin
								want_fail = 1'b1;
								fail_code = ERR_EXP;
							end
						end
					end else begin
						// a lone e splits off as an identifier
						n_mode = M_TAIL;
					end
				end
				M_TAIL: begin
					if (c0 == CH_DOT) begin
						want_fail = 1'b1;
						fail_code = ERR_DOT;
					end else begin
						want_emit = 1'b1;
						emit_kind = TK_NUM;
						emit_num = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_id_cont(c0)) it_adv = 2'd1;
					else begin
						want_emit = 1'b1;
						emit_kind = TK_IDENT;
					end
				end
				default: n_mode = M_IDLE;
			endcase
		end
	end

	// positions after the step's advances
	assign pos1 = (it_adv != 2'd0) ? adv_pos(cur_q, held_q[0]) : cur_q;
	assign pos2 = (it_adv == 2'd2) ? adv_pos(pos1, held_q[1]) : pos1;

	// resolve emit against the budgets
	always_comb begin
		it_res = 1'b0;
		it_fin = 1'b0;
		n_tcnt = tcnt_q;
		mode_fin = n_mode;
		it_r.kind = TK_END;
		it_r.err = ERR_NONE;
		it_r.start = it_mark ? cur_q : start_q;
		it_r.fin = pos2;
		it_r.done = 1'b1;
		if (want_fail) begin
			it_res = 1'b1;
			it_fin = 1'b1;
			it_r.err = fail_code;
		end else if (want_emit) begin
			it_res = 1'b1;
			mode_fin = M_IDLE;
			if ({1'b0, tcnt_q} + 17'd1 > {1'b0, max_tokens}) begin
				it_fin = 1'b1;
				it_r.err = ERR_TOKENS;
			end else if (emit_num && dcnt_q > {1'b0, max_digits}) begin
				it_fin = 1'b1;
				it_r.err = ERR_DIGITS;
			end else begin
				it_r.kind = emit_kind;
				it_r.done = emit_kind == TK_END;
				it_fin = emit_kind == TK_END;
				n_tcnt = tcnt_q + 16'd1;
			end
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_TAKE: if (item_valid && !drop_q) phase_d = PH_RUN;
			PH_RUN:  if (step_go && wrap) phase_d = PH_TAKE;
			default: phase_d = PH_TAKE;
		endcase
	end

	// phase outputs
	always_comb begin
		item_ready = 1'b0;
		step_go = 1'b0;
		unique case (phase_q)
			PH_TAKE: item_ready = 1'b1;
			PH_RUN:  step_go = res_ready;
			default: item_ready = 1'b0;
		endcase
	end

	assign take = item_valid && item_ready;
	assign wrap = fin_q || it_ret;
	assign apply = step_go && !wrap;
	assign take_push = item.has && (btaken_q < BT_W'(TEXT_LEN_MAX)) && (hcnt_q != 2'd3);

	assign res_valid = step_go && pend_valid_q && (wrap || it_res);
	assign res = '{res: pend_q, last: wrap};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAKE;
			mode_q <= M_IDLE;
			start_q <= POS_RST;
			cur_q <= POS_RST;
			hcnt_q <= '0;
			dcnt_q <= '0;
			tcnt_q <= '0;
			flags_q <= '0;
			drop_q <= 1'b0;
			ended_q <= 1'b0;
			fin_q <= 1'b0;
			btaken_q <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if ((take && drop_q && item.eot) || (step_go && wrap && ended_q)) begin
				// end of text: back to a fresh text
				mode_q <= M_IDLE;
				start_q <= POS_RST;
				cur_q <= POS_RST;
				hcnt_q <= '0;
				dcnt_q <= '0;
				tcnt_q <= '0;
				flags_q <= '0;
				drop_q <= 1'b0;
				ended_q <= 1'b0;
				fin_q <= 1'b0;
				btaken_q <= '0;
				pend_valid_q <= 1'b0;
			end else if (take && !drop_q) begin
				ended_q <= item.eot;
				if (take_push) begin
					hcnt_q <= hcnt_q + 2'd1;
					btaken_q <= btaken_q + BT_W'(1);
				end
			end else if (step_go && wrap) begin
				pend_valid_q <= 1'b0;
				if (fin_q) drop_q <= 1'b1;
			end else if (apply) begin
				mode_q <= mode_fin;
				if (it_mark) start_q <= cur_q;
				cur_q <= pos2;
				hcnt_q <= hcnt_q - it_adv;
				dcnt_q <= n_dcnt;
				tcnt_q <= n_tcnt;
				flags_q <= n_flags;
				fin_q <= it_fin;
				if (it_res) pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !drop_q && take_push) held_q[hcnt_q] <= item.chr;
		else if (apply) begin
			if (it_res) pend_q <= it_r;
			case (it_adv)
				2'd1: begin
					held_q[0] <= held_q[1];
					held_q[1] <= held_q[2];
				end
				2'd2: held_q[0] <= held_q[2];
				default: held_q[0] <= held_q[0];
			endcase
		end
	end

endmodule

// ===== rtl/calc_expression_tokenizer.sv =====
// top level of the expression tokenizer: input queue, lexer engine, result queue
// depends on cet_pkg, cet_fifo, cet_front and cet_back
//
// channel | handshake            | payload
// in      | in_valid / in_ready  | char_byte, has_char, end_of_text
// out     | out_valid/out_ready  | token_kind .. text_done
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// the engine takes an item, then runs one lexer step per cycle until it needs more input
// or the text is finished or has failed; every mode change or released token adds one step;
// empty items never reach the engine, as the input queue drops them
// steps stall while the result queue is full; the input queue keeps taking items until full
// reset returns all lexer state and the registers to their reset values
module calc_expression_tokenizer import cet_pkg::*; #(
	parameter int unsigned TEXT_LEN_MAX = TEXT_LEN_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        has_char,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [3:0]  error_code,
	output logic [15:0] start_offset,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [15:0] end_offset,
	output logic [15:0] end_line,
	output logic [15:0] end_column,
	output logic        last_of_run,
	output logic        text_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	logic [15:0] max_tokens_q;
	logic [9:0] max_digits_q;
	logic q_valid, q_ready;
	in_item_t q_item;
	logic r_valid, r_ready;
	out_item_t r_item, o_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_tokens_q <= MAX_TOKENS_RST;
			max_digits_q <= MAX_DIGITS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_TOKENS: max_tokens_q <= cfg_data;
				CFG_MAX_DIGITS: max_digits_q <= cfg_data[9:0];
				default: max_tokens_q <= max_tokens_q;
			endcase
		end
	end

	cet_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_byte(char_byte),
		.has_char(has_char),
		.end_of_text(end_of_text),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_item(q_item)
	);

	cet_back #(
		.TEXT_LEN_MAX(TEXT_LEN_MAX)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.max_tokens(max_tokens_q),
		.max_digits(max_digits_q),
		.item_valid(q_valid),
		.item_ready(q_ready),
		.item(q_item),
		.res_valid(r_valid),
		.res_ready(r_ready),
		.res(r_item)
	);

	cet_fifo #(
		.WIDTH($bits(out_item_t)),
		.DEPTH(OUT_Q_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(r_valid),
		.wr_ready(r_ready),
		.wr_data(r_item),
		.rd_valid(out_valid),
		.rd_ready(out_ready),
		.rd_data(o_item)
	);

	assign token_kind = o_item.res.kind;
	assign error_code = o_item.res.err;
	assign start_offset = o_item.res.start.off;
	assign start_line = o_item.res.start.line;
	assign start_column = o_item.res.start.col;
	assign end_offset = o_item.res.fin.off;
	assign end_line = o_item.res.fin.line;
	assign end_column = o_item.res.fin.col;
	assign last_of_run = o_item.last;
	assign text_done = o_item.res.done;

endmodule

// ===== test/calc_expression_tokenizer_tb.sv =====
// testbench for calc_expression_tokenizer: feeds source texts byte by byte and checks tokens
// holds its own lexer predictor; depends on cet_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module calc_expression_tokenizer_tb import cet_pkg::*;;

	localparam int LIMIT_CYCLES = 1500000;

	typedef struct {
		logic [4:0] kind;
		logic [3:0] err;
		pos_t start;
		pos_t fin;
		logic last;
		logic done;
	} token_rec_t;

	logic clk, arst_n;
	logic in_valid, in_ready, has_char, end_of_text;
	logic [7:0] char_byte;
	logic out_valid, out_ready;
	logic [4:0] token_kind;
	logic [3:0] error_code;
	logic [15:0] start_offset, start_line, start_column, end_offset, end_line, end_column;
	logic last_of_run, text_done;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [15:0] cfg_data;

	calc_expression_tokenizer u_dut (.*);

	// predictor state
	int max_tokens, max_digits;
	lex_mode_t lx_mode;
	pos_t tok_pos, cur;
	logic [7:0] held [3];
	int held_n, digit_cnt, tok_cnt, taken;
	logic [4:0] lit_flags;
	bit dropping, txt_ended, txt_fin;
	token_rec_t run_res[$];
	token_rec_t expected_tokens[$];

	int fail_cnt = 0;
	int cycle_cnt = 0;
	int burst_left = 0;
	bit no_gaps = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int items_sent = 0;
	logic [7:0] txt_q[$];

	always #5 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic logic [7:0] peek(input int k);
		return (k < held_n) ? held[k] : 8'd0;
	endfunction

	function automatic bit have(input int k);
		return held_n >= k || txt_ended;
	endfunction

	function automatic bit dig(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit ident_ch(input logic [7:0] c);
		return alpha(c) || dig(c) || c == CH_USCORE;
	endfunction

	function automatic void step_cursor();
		logic [7:0] c;
		if (held_n == 0) return;
		c = held[0];
		held[0] = held[1];
		held[1] = held[2];
		held_n--;
		if (cur.off != POS_CAP) cur.off++;
		if (c == CH_LF) begin
			if (cur.line != POS_CAP) cur.line++;
			cur.col = 16'd1;
		end else if (cur.col != POS_CAP) begin
			cur.col++;
		end
	endfunction

	function automatic void count_digit();
		if (digit_cnt < 1024) digit_cnt++;
	endfunction

	function automatic void put_token(input logic [4:0] kind, input logic [3:0] err,
			input bit done);
		token_rec_t r;
		if (run_res.size() >= 4) return;
		r.kind = kind;
		r.err = err;
		r.start = tok_pos;
		r.fin = cur;
		r.last = 1'b0;
		r.done = done;
		run_res.insert(run_res.size(), r);
	endfunction

	function automatic void lex_fail(input logic [3:0] code);
		put_token(TK_END, code, 1'b1);
		txt_fin = 1;
	endfunction

	function automatic void emit_token(input logic [4:0] kind, input bit number);
		lx_mode = M_IDLE;
		if (tok_cnt + 1 > max_tokens) begin
			lex_fail(ERR_TOKENS);
			return;
		end
		if (number && digit_cnt > max_digits) begin
			lex_fail(ERR_DIGITS);
			return;
		end
		put_token(kind, ERR_NONE, kind == TK_END);
		tok_cnt++;
		if (kind == TK_END) txt_fin = 1;
	endfunction

	function automatic logic [4:0] op_kind(input logic [7:0] c);
		case (c)
			CH_PLUS: return TK_PLUS;
			CH_MINUS: return TK_MINUS;
			CH_STAR: return TK_STAR;
			CH_SLASH: return TK_SLASH;
			CH_CARET: return TK_CARET;
			CH_LPAR: return TK_LPAR;
			CH_RPAR: return TK_RPAR;
			CH_LBRK: return TK_LBRK;
			CH_RBRK: return TK_RBRK;
			CH_LBRC: return TK_LBRC;
			CH_RBRC: return TK_RBRC;
			CH_COMMA: return TK_COMMA;
			CH_PCT: return TK_PCT;
			CH_AT: return TK_AT;
			default: return TK_END;
		endcase
	endfunction

	function automatic void lex_pair(input logic [7:0] c);
		bit eq;
		tok_pos = cur;
		step_cursor();
		eq = peek(0) == CH_EQ;
		if (eq) step_cursor();
		case (c)
			CH_COLON: if (eq) emit_token(TK_ASSIGN, 1'b0); else lex_fail(ERR_COLON);
			CH_LT: emit_token(eq ? TK_LE : TK_LT, 1'b0);
			CH_GT: emit_token(eq ? TK_GE : TK_GT, 1'b0);
			CH_EQ: if (eq) emit_token(TK_EQ, 1'b0); else lex_fail(ERR_LONE_EQ);
			default: emit_token(eq ? TK_NE : TK_NOT, 1'b0);
		endcase
	endfunction

	// returns 0 when more bytes are needed
	function automatic bit lex_idle();
		logic [7:0] c;
		logic [4:0] k;
		c = peek(0);
		if (held_n == 0) begin
			if (!txt_ended) return 0;
			tok_pos = cur;
			emit_token(TK_END, 1'b0);
			return 1;
		end
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
			step_cursor();
			return 1;
		end
		if (dig(c)) begin
			tok_pos = cur;
			digit_cnt = 0;
			lit_flags = '0;
			lit_flags[LF_ZERO] = c == CH_ZERO;
			lx_mode = M_INT;
			return 1;
		end
		if (c == CH_DOT) begin
			if (!have(2)) return 0;
			tok_pos = cur;
			step_cursor();
			if (dig(peek(0))) begin
				digit_cnt = 0;
				lit_flags = '0;
				lx_mode = M_FRAC;
			end else begin
				lex_fail(ERR_CHAR);
			end
			return 1;
		end
		if (alpha(c) || c == CH_USCORE) begin
			tok_pos = cur;
			lx_mode = M_IDENT;
			return 1;
		end
		if (c == CH_QUOTE) begin
			tok_pos = cur;
			step_cursor();
			lit_flags = '0;
			lx_mode = M_STR;
			return 1;
		end
		k = op_kind(c);
		if (k != TK_END) begin
			tok_pos = cur;
			step_cursor();
			emit_token(k, 1'b0);
			return 1;
		end
		if (c == CH_COLON || c == CH_LT || c == CH_GT || c == CH_EQ || c == CH_BANG) begin
			if (!have(2)) return 0;
			lex_pair(c);
			return 1;
		end
		tok_pos = cur;
		step_cursor();
		lex_fail(ERR_CHAR);
		return 1;
	endfunction

	function automatic void lex_run();
		logic [7:0] c;
		while (!txt_fin) begin
			c = peek(0);
			if (lx_mode == M_IDLE) begin
				if (!lex_idle()) return;
			end else if (lx_mode == M_STR) begin
				if (held_n == 0) begin
					if (txt_ended) lex_fail(ERR_STRING);
					return;
				end
				step_cursor();
				if (lit_flags[LF_ESC]) lit_flags[LF_ESC] = 0;
				else if (c == CH_BSLASH) lit_flags[LF_ESC] = 1;
				else if (c == CH_QUOTE) emit_token(TK_STR, 1'b0);
			end else begin
				if (!have(1)) return;
				case (lx_mode)
					M_INT: begin
						if (dig(c)) begin
							if (digit_cnt != 0) lit_flags[LF_MULTI] = 1;
							count_digit();
							step_cursor();
						end else if (c == CH_HASH) begin
							step_cursor();
							lit_flags[LF_DIGIT] = 0;
							lit_flags[LF_POINT] = 0;
							lx_mode = M_RADIX;
						end else if (lit_flags[LF_ZERO] && !lit_flags[LF_MULTI] &&
								(c == "b" || c == "B" || c == "o" || c == "O" ||
								c == "x" || c == "X")) begin
							step_cursor();
							lit_flags[LF_DIGIT] = 0;
							lx_mode = M_PREFIX;
						end else if (c == CH_DOT) begin
							step_cursor();
							lx_mode = M_FRAC;
						end else begin
							lx_mode = M_EXPCHK;
						end
					end
					M_FRAC, M_EXPDIG: begin
						if (dig(c)) begin
							count_digit();
							step_cursor();
						end else begin
							lx_mode = (lx_mode == M_FRAC) ? M_EXPCHK : M_TAIL;
						end
					end
					M_RADIX: begin
						if (alpha(c) || dig(c)) begin
							lit_flags[LF_DIGIT] = 1;
							count_digit();
							step_cursor();
						end else if (c == CH_DOT) begin
							if (lit_flags[LF_POINT]) lex_fail(ERR_POINT2);
							else begin
								lit_flags[LF_POINT] = 1;
								step_cursor();
							end
						end else if (lit_flags[LF_DIGIT]) emit_token(TK_NUM, 1'b1);
						else lex_fail(ERR_RADIX);
					end
					M_PREFIX: begin
						if (alpha(c) || dig(c)) begin
							lit_flags[LF_DIGIT] = 1;
							count_digit();
							step_cursor();
						end else if (lit_flags[LF_DIGIT]) emit_token(TK_NUM, 1'b1);
						else lex_fail(ERR_PREFIX);
					end
					M_EXPCHK: begin
						if (c != "e" && c != "E") lx_mode = M_TAIL;
						else if (!have(2)) return;
						else if (dig(peek(1))) begin
							step_cursor();
							lx_mode = M_EXPDIG;
						end else if (peek(1) == CH_PLUS || peek(1) == CH_MINUS) begin
							if (!have(3)) return;
							step_cursor();
							step_cursor();
							if (dig(peek(0))) lx_mode = M_EXPDIG;
							else lex_fail(ERR_EXP);
						end else begin
							lx_mode = M_TAIL;
						end
					end
					M_TAIL: begin
						if (c == CH_DOT) lex_fail(ERR_DOT);
						else emit_token(TK_NUM, 1'b1);
					end
					M_IDENT: begin
						if (ident_ch(c)) step_cursor();
						else emit_token(TK_IDENT, 1'b0);
					end
					default: lx_mode = M_IDLE;
				endcase
			end
		end
	endfunction

	function automatic void text_clear();
		lx_mode = M_IDLE;
		tok_pos = POS_RST;
		cur = POS_RST;
		held_n = 0;
		digit_cnt = 0;
		tok_cnt = 0;
		lit_flags = '0;
		dropping = 0;
		taken = 0;
		txt_ended = 0;
		txt_fin = 0;
	endfunction

	function automatic void predict_tokens(input logic [7:0] b, input logic h, input logic e);
		run_res.delete();
		if (dropping) begin
			if (e) text_clear();
			return;
		end
		if (h && taken < TEXT_LEN_MAX_DEF && held_n < 3) begin
			held[held_n] = b;
			held_n++;
			taken++;
		end
		txt_ended = e;
		lex_run();
		if (e) text_clear();
		else if (txt_fin) dropping = 1;
		if (run_res.size() > 0) run_res[run_res.size() - 1].last = 1;
		foreach (run_res[i]) expected_tokens.insert(expected_tokens.size(), run_res[i]);
	endfunction

	// ---------------- driving ----------------
	task automatic send_item(input logic [7:0] b, input logic h, input logic e);
		int gap;
		bit acc;
		gap = 0;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end
			burst_left--;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= b;
		has_char <= h;
		end_of_text <= e;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
		predict_tokens(b, h, e);
		if (h || e) items_sent++;
	endtask

	task automatic send_text(input bit split_end);
		foreach (txt_q[i])
			send_item(txt_q[i], 1'b1, (i == txt_q.size() - 1) && !split_end);
		if (split_end || txt_q.size() == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		txt_q.delete();
	endtask

	task automatic send_str(input string s, input bit split_end);
		for (int i = 0; i < s.len(); i++) txt_q.insert(txt_q.size(), s[i]);
		send_text(split_end);
	endtask

	// sender pauses until the block has delivered everything
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		bit acc;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			acc = cfg_ready;
			@(posedge clk);
		end while (!acc);
		cfg_valid <= 1'b0;
		if (idx == CFG_MAX_TOKENS) max_tokens = int'(val);
		else max_digits = int'(val[9:0]);
	endtask

	// one random lexeme appended to the text under construction
	task automatic add_lexeme();
		string s;
		case ($urandom_range(0, 27))
			0, 1: s = $sformatf("%0d", $urandom_range(0, 99999));
			2: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 999));
			3: s = $sformatf("%0de%s%0d", $urandom_range(1, 9),
				$urandom_range(0, 1) ? "+" : "-", $urandom_range(0, 99));
			4: s = $sformatf("%0dE%0d", $urandom_range(0, 9), $urandom_range(0, 9));
			5: s = ($urandom_range(0, 1)) ? "16#fF.a" : "2#101";
			6: s = ($urandom_range(0, 1)) ? "0x1F" : "0o17";
			7: s = ($urandom_range(0, 1)) ? "0b101" : ".25";
			8: s = "4e";
			9, 10: s = ($urandom_range(0, 1)) ? "abc_1" : "_Zq9";
			11: s = ($urandom_range(0, 1)) ? "\"a\\\"b c\"" : "\"\"";
			12, 13: begin
				s = "+-*/^()[]{},%@";
				s = s.substr($urandom_range(0, 13), 13);
				s = s.substr(0, 0);
			end
			14: s = ($urandom_range(0, 1)) ? ":=" : "<=";
			15: s = ($urandom_range(0, 1)) ? "<" : ">=";
			16: s = ($urandom_range(0, 1)) ? ">" : "==";
			17: s = ($urandom_range(0, 1)) ? "!=" : "!";
			18, 19: s = ($urandom_range(0, 1)) ? "\n" : "\t";
			20: s = "123456";
			21: s = "e";
			22: s = "0X";
			default: s = " ";
		endcase
		if ($urandom_range(0, 39) == 0) begin
			// rare breakage: bad char, lone colon or equals, radix, exponent and trailing dot faults
			case ($urandom_range(0, 6))
				0: s = "$";
				1: s = ": ";
				2: s = "=1";
				3: s = "1#.2.";
				4: s = "8# ";
				5: s = "5e+x";
				default: s = "1.5.";
			endcase
		end
		for (int i = 0; i < s.len(); i++) txt_q.insert(txt_q.size(), s[i]);
		if ($urandom_range(0, 2) != 0) txt_q.insert(txt_q.size(), CH_SPACE);
		if ($urandom_range(0, 60) == 0)
			txt_q.insert(txt_q.size(), 8'($urandom_range(0, 255)));
	endtask

	task automatic random_text(input int lexemes);
		repeat (lexemes) add_lexeme();
		if ($urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		send_text(1'($urandom_range(0, 1)));
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		send_str("0x1F+ab_9\n\"q\\\"\"", 1'b0);
		send_str("3e x<=", 1'b1);
		send_str(".5 :", 1'b0);
		send_str("$ 1", 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_str("\"ab", 1'b0);
	endtask

	task automatic test_budgets();
		wait_idle();
		write_reg(CFG_MAX_TOKENS, 16'd1);
		write_reg(CFG_MAX_DIGITS, 16'd1);
		repeat (4) random_text($urandom_range(1, 4));
		send_str("7", 1'b0);
		wait_idle();
		write_reg(CFG_MAX_TOKENS, 16'd4);
		write_reg(CFG_MAX_DIGITS, 16'd3);
		repeat (3) random_text($urandom_range(2, 8));
		wait_idle();
		write_reg(CFG_MAX_TOKENS, 16'd0);
		write_reg(CFG_MAX_DIGITS, 16'd0);
		send_str("x", 1'b0);
		send_str("12", 1'b1);
		wait_idle();
		write_reg(CFG_MAX_TOKENS, 16'd65535);
		write_reg(CFG_MAX_DIGITS, 16'd1023);
	endtask

	task automatic test_random();
		int target;
		target = items_sent + 120;
		while (items_sent < target) random_text($urandom_range(1, 12));
	endtask

	task automatic test_backpressure();
		wait_idle();
		hold_req = 1;
		repeat (10) begin
			txt_q.insert(txt_q.size(), CH_LT);
			txt_q.insert(txt_q.size(), CH_SPACE);
			txt_q.insert(txt_q.size(), CH_PLUS);
		end
		send_text(1'b0);
		wait_idle();
	endtask

	// spaces offered back to back with no gaps from the sender, then a short text
	task automatic test_long_text();
		no_gaps = 1;
		repeat (20) send_item(CH_SPACE, 1'b1, 1'b0);
		no_gaps = 0;
		send_str("ab", 1'b0);
	endtask

	// ---------------- checking ----------------
	task automatic check_field(input string nm, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	always @(negedge clk) begin
		token_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token kind %0d err %0d, expected none",
					$time, token_kind, error_code);
				fail_cnt++;
			end else begin
				e = expected_tokens.pop_front();
				check_field("token_kind", 16'(e.kind), 16'(token_kind));
				check_field("error_code", 16'(e.err), 16'(error_code));
				check_field("start_offset", e.start.off, start_offset);
				check_field("start_line", e.start.line, start_line);
				check_field("start_column", e.start.col, start_column);
				check_field("end_offset", e.fin.off, end_offset);
				check_field("end_line", e.fin.line, end_line);
				check_field("end_column", e.fin.col, end_column);
				check_field("last_of_run", 16'(e.last), 16'(last_of_run));
				check_field("text_done", 16'(e.done), 16'(text_done));
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt % 97 == 0) stall_mode = $urandom_range(0, 2);
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		char_byte = 0;
		has_char = 0;
		end_of_text = 0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		max_tokens = 65535;
		max_digits = 1023;
		text_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_budgets();
		test_random();
		test_backpressure();
		test_long_text();
		wait_idle();
		if (fail_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
